// ----- rtl/fpba_pkg.sv -----
// Shared types and constants for the fit-policy block allocator.
// Used by the controller, the datapath, the top level and the port checker.
package fpba_pkg;

  localparam int MAX_BLOCKS_DEF = 16;
  localparam int SIZE_BITS_DEF  = 16;

  // Stream payload layout
  localparam int CMD_W       = 2;
  localparam int BLK_W       = 4;
  localparam int SIZE_W      = 16;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 24;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;
  localparam logic [CFG_IDX_W-1:0] CFG_POLICY     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_BLOCKS = 1'd1;
  localparam logic [CFG_DATA_W-1:0] NUM_BLOCKS_RST = 5'd16;

  // Commands
  localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RESTART = 2'd1;
  localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd2;

  // Policies
  localparam logic [1:0] POL_FIRST = 2'd0;
  localparam logic [1:0] POL_BEST  = 2'd1;
  localparam logic [1:0] POL_NEXT  = 2'd2;
  localparam logic [1:0] POL_WORST = 2'd3;

  typedef struct packed {
    logic accept;
    logic walk_start;
    logic load_wr;
    logic commit;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic walk_done;
    logic out_free;
    logic is_alloc;
  } ctrl_stat_t;

endpackage

// ----- rtl/fit_policy_block_allocator_unit.sv -----
// Top level: fit-policy block allocator (first, best, next and worst fit).
// The table walk reads one block per cycle. One item at a time: the next item can be
// taken in the cycle after its result enters the output register. Synchronous reset clears
// all sizes and the pointer, restores default config.
module fit_policy_block_allocator_unit #(
  parameter int MAX_BLOCKS = fpba_pkg::MAX_BLOCKS_DEF,
  parameter int SIZE_BITS  = fpba_pkg::SIZE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [fpba_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fpba_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // cmd[1:0], block_index[5:2], size_value[21:6], zero pad
  input  logic [fpba_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // granted[0], chosen_block[4:1], remaining_size[20:5], zero pad
  output logic [fpba_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  fpba_pkg::ctrl_cmd_t  cmd;
  fpba_pkg::ctrl_stat_t stat;

  fpba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_cmd   (s_axis_tdata[1:0]),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  fpba_datapath #(.MAX_BLOCKS(MAX_BLOCKS), .SIZE_BITS(SIZE_BITS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (s_axis_tdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

endmodule

// ----- rtl/fpba_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fpba_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AddrW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AddrW-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/fpba_datapath.sv -----
// Datapath: size tables, table walk (scan and restart copy), pick and output register.
// Depends on fpba_pkg and fpba_ram.
module fpba_datapath #(
  parameter int MAX_BLOCKS = fpba_pkg::MAX_BLOCKS_DEF,
  parameter int SIZE_BITS  = fpba_pkg::SIZE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [fpba_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fpba_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic [fpba_pkg::IN_TDATA_W-1:0]  in_data,
  input  fpba_pkg::ctrl_cmd_t              cmd,
  output fpba_pkg::ctrl_stat_t             stat,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [fpba_pkg::OUT_TDATA_W-1:0] out_data
);

  localparam int IdxW = $clog2(MAX_BLOCKS);
  localparam int CntW = $clog2(MAX_BLOCKS + 1);

  // Configuration
  logic [1:0]                      policy;
  logic [fpba_pkg::CFG_DATA_W-1:0] num_blocks;
  logic [CntW-1:0]                 count;

  // Latched item
  logic [fpba_pkg::CMD_W-1:0] cmd_r;
  logic [fpba_pkg::BLK_W-1:0] idx_r;
  logic [SIZE_BITS-1:0]       val_r;

  // Walk
  logic [IdxW-1:0] rd_addr;
  logic [IdxW-1:0] rd_addr_next;
  logic [CntW-1:0] issue_cnt;
  logic [CntW-1:0] wrap_lim;
  logic [IdxW-1:0] start_addr;
  logic            rd_vld;
  logic [IdxW-1:0] rd_idx;

  // Selection and state
  logic                  found;
  logic [IdxW-1:0]       sel_idx;
  logic [SIZE_BITS-1:0]  sel_size;
  logic [IdxW-1:0]       np;
  logic [MAX_BLOCKS-1:0] cur_valid;
  logic [MAX_BLOCKS-1:0] orig_valid;

  // Result
  logic                              res_granted;
  logic [fpba_pkg::BLK_W-1:0]        res_blk;
  logic [fpba_pkg::SIZE_W-1:0]       res_rem;

  // Tables
  logic                 cur_we;
  logic [IdxW-1:0]      cur_waddr;
  logic [SIZE_BITS-1:0] cur_wdata;
  logic [SIZE_BITS-1:0] cur_rdata;
  logic                 orig_we;
  logic [SIZE_BITS-1:0] orig_rdata;

  logic [fpba_pkg::CMD_W-1:0] in_cmd;
  logic [SIZE_BITS-1:0]       cur_size;
  logic                       fits;
  logic                       take;
  logic                       load_ok;
  logic                       sweeping;
  logic [SIZE_BITS-1:0]       remain;

  assign in_cmd = in_data[1:0];

  always_comb begin
    if (int'(num_blocks) > MAX_BLOCKS) begin
      count = CntW'(MAX_BLOCKS);
    end else begin
      count = CntW'(num_blocks);
    end
  end

  // Next fit starts at block 0 when the kept pointer is past the blocks in use
  assign start_addr = (policy == fpba_pkg::POL_NEXT && CntW'(np) < count) ? np : '0;
  assign wrap_lim   = (cmd_r == fpba_pkg::CMD_ALLOC) ? count : CntW'(MAX_BLOCKS);
  assign rd_addr_next = (CntW'(rd_addr) + CntW'(1) == wrap_lim) ? '0 : rd_addr + IdxW'(1);

  assign sweeping = rd_vld && (cmd_r == fpba_pkg::CMD_RESTART);
  assign cur_size = cur_valid[rd_idx] ? cur_rdata : '0;
  assign fits     = cur_size >= val_r;

  always_comb begin
    take = 1'b0;
    if (rd_vld && cmd_r == fpba_pkg::CMD_ALLOC && fits) begin
      if (!found) begin
        take = 1'b1;
      end else if (policy == fpba_pkg::POL_BEST && cur_size < sel_size) begin
        take = 1'b1;
      end else if (policy == fpba_pkg::POL_WORST && cur_size > sel_size) begin
        take = 1'b1;
      end
    end
  end

  assign load_ok = int'(idx_r) < MAX_BLOCKS;
  assign remain  = sel_size - val_r;
  assign orig_we = cmd.load_wr && load_ok;

  always_comb begin
    cur_we    = 1'b0;
    cur_waddr = rd_idx;
    cur_wdata = remain;
    if (cmd.load_wr && load_ok) begin
      cur_we    = 1'b1;
      cur_waddr = IdxW'(idx_r);
      cur_wdata = val_r;
    end else if (sweeping) begin
      cur_we    = 1'b1;
      cur_wdata = orig_valid[rd_idx] ? orig_rdata : '0;
    end else if (cmd.commit && found) begin
      cur_we    = 1'b1;
      cur_waddr = sel_idx;
    end
  end

  fpba_ram #(.WIDTH(SIZE_BITS), .DEPTH(MAX_BLOCKS)) u_cur_ram (
    .clk   (clk),
    .we    (cur_we),
    .waddr (cur_waddr),
    .wdata (cur_wdata),
    .raddr (rd_addr),
    .rdata (cur_rdata)
  );

  fpba_ram #(.WIDTH(SIZE_BITS), .DEPTH(MAX_BLOCKS)) u_orig_ram (
    .clk   (clk),
    .we    (orig_we),
    .waddr (IdxW'(idx_r)),
    .wdata (val_r),
    .raddr (rd_addr),
    .rdata (orig_rdata)
  );

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      policy     <= fpba_pkg::POL_FIRST;
      num_blocks <= fpba_pkg::NUM_BLOCKS_RST;
      np         <= '0;
      cur_valid  <= '0;
      orig_valid <= '0;
      issue_cnt  <= '0;
      rd_vld     <= 1'b0;
      found      <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          fpba_pkg::CFG_POLICY:     policy     <= cfg_data[1:0];
          fpba_pkg::CFG_NUM_BLOCKS: num_blocks <= cfg_data;
          default: ;
        endcase
      end

      rd_vld <= issue_cnt != '0;
      if (cmd.walk_start) begin
        if (in_cmd == fpba_pkg::CMD_RESTART) begin
          issue_cnt <= CntW'(MAX_BLOCKS);
          np        <= '0;
        end else begin
          issue_cnt <= count;
        end
      end else if (issue_cnt != '0) begin
        issue_cnt <= issue_cnt - CntW'(1);
      end

      if (cmd.accept) begin
        found <= 1'b0;
      end else if (take) begin
        found <= 1'b1;
      end

      if (orig_we) begin
        orig_valid[IdxW'(idx_r)] <= 1'b1;
      end
      if (cur_we) begin
        cur_valid[cur_waddr] <= 1'b1;
      end

      if (cmd.commit && found && policy == fpba_pkg::POL_NEXT) begin
        np <= sel_idx;
      end

      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cmd_r       <= in_cmd;
      idx_r       <= in_data[5:2];
      val_r       <= SIZE_BITS'(in_data[21:6]);
      res_granted <= 1'b0;
      res_blk     <= '0;
      res_rem     <= '0;
    end else if (cmd.commit && found) begin
      res_granted <= 1'b1;
      res_blk     <= fpba_pkg::BLK_W'(sel_idx);
      res_rem     <= fpba_pkg::SIZE_W'(remain);
    end

    if (cmd.walk_start) begin
      rd_addr <= (in_cmd == fpba_pkg::CMD_RESTART) ? '0 : start_addr;
    end else if (issue_cnt != '0) begin
      rd_addr <= rd_addr_next;
    end
    rd_idx <= rd_addr;

    if (take) begin
      sel_idx  <= rd_idx;
      sel_size <= cur_size;
    end

    if (cmd.out_load) begin
      out_data <= {3'b000, res_rem, res_blk, res_granted};
    end
  end

  assign stat.walk_done = (issue_cnt == '0) && !rd_vld;
  assign stat.out_free  = !out_valid || out_ready;
  assign stat.is_alloc  = cmd_r == fpba_pkg::CMD_ALLOC;

endmodule

// ----- rtl/fpba_ctrl.sv -----
// Controller state machine: sequences accept, table load, walk, commit and result.
// Depends on fpba_pkg.
module fpba_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic [fpba_pkg::CMD_W-1:0] in_cmd,
  output logic                       in_ready,
  input  fpba_pkg::ctrl_stat_t       stat,
  output fpba_pkg::ctrl_cmd_t        cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_LOAD   = 3'd1;
  localparam logic [2:0] S_WALK   = 3'd2;
  localparam logic [2:0] S_COMMIT = 3'd3;
  localparam logic [2:0] S_RESULT = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready       = state == S_IDLE;
  assign cmd.accept     = in_valid && in_ready;
  assign cmd.walk_start = cmd.accept &&
                          (in_cmd == fpba_pkg::CMD_RESTART || in_cmd == fpba_pkg::CMD_ALLOC);
  assign cmd.load_wr    = state == S_LOAD;
  assign cmd.commit     = state == S_COMMIT;
  assign cmd.out_load   = (state == S_RESULT) && stat.out_free;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd.accept) begin
          unique case (in_cmd) inside
            fpba_pkg::CMD_LOAD:                       state_next = S_LOAD;
            fpba_pkg::CMD_RESTART, fpba_pkg::CMD_ALLOC: state_next = S_WALK;
            default:                                  state_next = S_RESULT;
          endcase
        end
      end
      S_LOAD:   state_next = S_RESULT;
      S_WALK: begin
        if (stat.walk_done) begin
          state_next = stat.is_alloc ? S_COMMIT : S_RESULT;
        end
      end
      S_COMMIT: state_next = S_RESULT;
      S_RESULT: begin
        if (stat.out_free) begin
          state_next = S_IDLE;
        end
      end
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- rtl/fpba_checker.sv -----
// Port-level checker for the allocator, bound to the top level.
// Depends on fpba_pkg.
module fpba_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [fpba_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  // Output register is empty right after reset
  a_rst_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // One item at a time: no transfer in back-to-back cycles
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while busy");

  // A refused request reports block 0 and size 0
  a_no_grant_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[20:1] == '0)
    else $error("nonzero fields on refused request");

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

endmodule

bind fit_policy_block_allocator_unit fpba_checker u_fpba_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ----- dv/testbench.sv -----
// Self-checking testbench for fit_policy_block_allocator_unit: directed and random command
// streams under all four fit policies, checked against a shadow allocation table.
// Depends on rtl/fpba_pkg.sv and the allocator RTL; needs no other files.
module testbench;

  localparam logic [fpba_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int NBLK = fpba_pkg::MAX_BLOCKS_DEF;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             cfg_we = 1'b0;
  logic [fpba_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
  logic [fpba_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
  logic                             s_axis_tvalid = 1'b0;
  logic                             s_axis_tready;
  // cmd[1:0], block_index[5:2], size_value[21:6], zero pad
  logic [fpba_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;
  // granted[0], chosen_block[4:1], remaining_size[20:5], zero pad
  logic [fpba_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

  bit idling = 1'b1;

  // first member lands in the high bits, so granted ends up at bit 0
  typedef struct packed {
    logic [fpba_pkg::SIZE_W-1:0] remaining;
    logic [fpba_pkg::BLK_W-1:0]  block;
    logic                        granted;
  } grant_t;

  class alloc_shadow;
    logic [1:0]                      policy;
    logic [fpba_pkg::CFG_DATA_W-1:0] blocks_reg;
    logic [fpba_pkg::SIZE_W-1:0]     cur_size [NBLK];
    logic [fpba_pkg::SIZE_W-1:0]     orig_size [NBLK];
    int unsigned                     next_ptr;
    grant_t                          expected_grants[$];
    int                              errors, loads, restarts, allocs, grants;

    function new();
      policy = fpba_pkg::POL_FIRST;
      blocks_reg = fpba_pkg::NUM_BLOCKS_RST;
      foreach (cur_size[i]) begin
        cur_size[i] = '0;
        orig_size[i] = '0;
      end
      next_ptr = 0;
      errors = 0;
      loads = 0;
      restarts = 0;
      allocs = 0;
      grants = 0;
    endfunction

    function void set_reg(logic [fpba_pkg::CFG_IDX_W-1:0] idx,
                          logic [fpba_pkg::CFG_DATA_W-1:0] data);
      if (idx == fpba_pkg::CFG_POLICY) begin
        policy = data[1:0];
      end else begin
        blocks_reg = data;
      end
    endfunction

    // Pick a block for the request, carve it out and return the grant.
    function grant_t fit_request(logic [fpba_pkg::SIZE_W-1:0] req);
      int unsigned count, p, sel;
      bit found;
      grant_t g;
      g = '0;
      found = 1'b0;
      sel = 0;
      count = (blocks_reg > NBLK) ? NBLK : blocks_reg;
      if (policy == fpba_pkg::POL_NEXT) begin
        // stale pointer restarts the scan at block zero
        p = (next_ptr < count) ? next_ptr : 0;
        for (int i = 0; i < count; i++) begin
          if (!found && cur_size[p] >= req) begin
            found = 1'b1;
            sel = p;
            next_ptr = p;
          end
          p = (p + 1 < count) ? p + 1 : 0;
        end
      end else begin
        for (int i = 0; i < count; i++) begin
          if (cur_size[i] >= req) begin
            if (!found) begin
              found = 1'b1;
              sel = i;
              if (policy == fpba_pkg::POL_FIRST) break;
            end else if (policy == fpba_pkg::POL_BEST && cur_size[i] < cur_size[sel]) begin
              sel = i;
            end else if (policy == fpba_pkg::POL_WORST && cur_size[i] > cur_size[sel]) begin
              sel = i;
            end
          end
        end
      end
      if (found) begin
        cur_size[sel] = cur_size[sel] - req;
        g.granted = 1'b1;
        g.block = sel[fpba_pkg::BLK_W-1:0];
        g.remaining = cur_size[sel];
      end
      return g;
    endfunction

    function void note_command(logic [fpba_pkg::CMD_W-1:0] cmd,
                               logic [fpba_pkg::BLK_W-1:0] idx,
                               logic [fpba_pkg::SIZE_W-1:0] val);
      grant_t g;
      g = '0;
      case (cmd)
        fpba_pkg::CMD_LOAD: begin
          orig_size[idx] = val;
          cur_size[idx] = val;
          loads++;
        end
        fpba_pkg::CMD_RESTART: begin
          foreach (cur_size[i]) cur_size[i] = orig_size[i];
          next_ptr = 0;
          restarts++;
        end
        fpba_pkg::CMD_ALLOC: begin
          g = fit_request(val);
          allocs++;
          grants += g.granted;
        end
        default: ;
      endcase
      expected_grants.push_back(g);
    endfunction

    function void check_grant(logic [fpba_pkg::OUT_TDATA_W-1:0] data);
      grant_t got, want;
      got = data[$bits(grant_t)-1:0];
      if (expected_grants.size() == 0) begin
        $display("%0t: result with no command pending: expected none,", $time);
        $display("  got granted=%0b block=%0d remaining=%0d",
                 got.granted, got.block, got.remaining);
        errors++;
        return;
      end
      want = expected_grants.pop_front();
      if (got.granted !== want.granted) begin
        $display("%0t: granted mismatch: expected %0b, got %0b",
                 $time, want.granted, got.granted);
        errors++;
      end
      if (got.block !== want.block) begin
        $display("%0t: chosen_block mismatch: expected %0d, got %0d",
                 $time, want.block, got.block);
        errors++;
      end
      if (got.remaining !== want.remaining) begin
        $display("%0t: remaining_size mismatch: expected %0d, got %0d",
                 $time, want.remaining, got.remaining);
        errors++;
      end
    endfunction
  endclass

  alloc_shadow shadow;

  fit_policy_block_allocator_unit dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #6000000;
    $display("Timeout: allocator stopped making progress");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic send_cmd(logic [fpba_pkg::CMD_W-1:0] cmd, logic [fpba_pkg::BLK_W-1:0] idx,
                          logic [fpba_pkg::SIZE_W-1:0] val);
    int gap;
    gap = 0;
    if (idling && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 19);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {2'b00, val, idx, cmd};
    do @(posedge clk); while (!s_axis_tready);
    shadow.note_command(cmd, idx, val);
  endtask

  // Hold the input idle until every outstanding result is back.
  task automatic drain(int extra);
    s_axis_tvalid <= 1'b0;
    while (shadow.expected_grants.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic set_config(logic [1:0] pol, logic [fpba_pkg::CFG_DATA_W-1:0] nblk);
    cfg_we <= 1'b1;
    cfg_index <= fpba_pkg::CFG_POLICY;
    cfg_data <= {3'b000, pol};
    @(posedge clk);
    shadow.set_reg(fpba_pkg::CFG_POLICY, {3'b000, pol});
    cfg_index <= fpba_pkg::CFG_NUM_BLOCKS;
    cfg_data <= nblk;
    @(posedge clk);
    shadow.set_reg(fpba_pkg::CFG_NUM_BLOCKS, nblk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(logic [1:0] pol, logic [fpba_pkg::CFG_DATA_W-1:0] nblk,
                           int items);
    int r;
    logic [fpba_pkg::SIZE_W-1:0] size, req;
    drain(4);
    set_config(pol, nblk);
    repeat (items) begin
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 7) == 0) begin
        size = fpba_pkg::SIZE_W'($urandom);
      end else begin
        size = fpba_pkg::SIZE_W'($urandom_range(0, 3000));
      end
      case ($urandom_range(0, 9))
        0:       req = '0;
        1:       req = fpba_pkg::SIZE_W'($urandom);
        default: req = fpba_pkg::SIZE_W'($urandom_range(1, 800));
      endcase
      if (r < 30) begin
        send_cmd(fpba_pkg::CMD_LOAD, fpba_pkg::BLK_W'($urandom), size);
      end else if (r < 37) begin
        send_cmd(fpba_pkg::CMD_RESTART, fpba_pkg::BLK_W'($urandom),
                 fpba_pkg::SIZE_W'($urandom));
      end else if (r < 39) begin
        send_cmd(CMD_UNUSED, fpba_pkg::BLK_W'($urandom), fpba_pkg::SIZE_W'($urandom));
      end else begin
        send_cmd(fpba_pkg::CMD_ALLOC, fpba_pkg::BLK_W'($urandom), req);
      end
    end
  endtask

  // Result side: check each transfer, then decide whether to stall.
  initial begin : result_sink
    int stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (m_axis_tvalid && m_axis_tready) shadow.check_grant(m_axis_tdata);
      if (stall > 0) begin
        stall--;
      end else if (idling && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 19);
      end
      m_axis_tready <= (stall == 0);
    end
  end

  initial begin
    shadow = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // empty table: a zero request still fits block zero, a request of one does not
    send_cmd(fpba_pkg::CMD_ALLOC, 4'd0, 16'd0);
    send_cmd(fpba_pkg::CMD_ALLOC, 4'd0, 16'd1);
    send_cmd(fpba_pkg::CMD_LOAD, 4'd0, 16'd100);
    send_cmd(fpba_pkg::CMD_LOAD, 4'd1, 16'd0);
    send_cmd(fpba_pkg::CMD_LOAD, 4'd3, 16'd50);
    send_cmd(fpba_pkg::CMD_LOAD, 4'd7, 16'd200);
    send_cmd(fpba_pkg::CMD_LOAD, 4'd9, 16'd50);
    send_cmd(fpba_pkg::CMD_LOAD, 4'd15, 16'hFFFF);
    send_cmd(fpba_pkg::CMD_ALLOC, 4'd0, 16'd40);
    send_cmd(fpba_pkg::CMD_ALLOC, 4'd0, 16'hFFFF);
    send_cmd(fpba_pkg::CMD_ALLOC, 4'd0, 16'hFFFF);
    send_cmd(CMD_UNUSED, 4'd15, 16'hFFFF);
    send_cmd(fpba_pkg::CMD_RESTART, 4'd0, 16'd0);
    drain(4);
    // best fit tie between blocks 3 and 9 goes to the lower index
    set_config(fpba_pkg::POL_BEST, 5'd16);
    send_cmd(fpba_pkg::CMD_ALLOC, 4'd0, 16'd45);
    drain(4);
    set_config(fpba_pkg::POL_WORST, 5'd16);
    send_cmd(fpba_pkg::CMD_ALLOC, 4'd0, 16'd10);
    drain(4);
    set_config(fpba_pkg::POL_NEXT, 5'd16);
    send_cmd(fpba_pkg::CMD_ALLOC, 4'd0, 16'd150);
    send_cmd(fpba_pkg::CMD_ALLOC, 4'd0, 16'd1000);
    drain(4);
    // pointer now sits past the shrunk table
    set_config(fpba_pkg::POL_NEXT, 5'd4);
    send_cmd(fpba_pkg::CMD_ALLOC, 4'd0, 16'd20);
    drain(4);
    set_config(fpba_pkg::POL_FIRST, 5'd0);
    send_cmd(fpba_pkg::CMD_ALLOC, 4'd0, 16'd0);
    drain(4);
    set_config(fpba_pkg::POL_BEST, 5'd31);
    send_cmd(fpba_pkg::CMD_ALLOC, 4'd0, 16'd1);

    run_phase(fpba_pkg::POL_FIRST, 5'd16, 100);
    run_phase(fpba_pkg::POL_BEST, 5'($urandom_range(2, 16)), 100);
    run_phase(fpba_pkg::POL_NEXT, 5'($urandom_range(2, 15)), 100);
    run_phase(fpba_pkg::POL_WORST, 5'd31, 100);
    run_phase(fpba_pkg::POL_FIRST, 5'd0, 50);
    run_phase(fpba_pkg::POL_BEST, 5'd1, 100);
    idling = 1'b0;
    run_phase(fpba_pkg::POL_NEXT, 5'd16, 120);
    run_phase(fpba_pkg::POL_WORST, 5'd16, 120);
    drain(NBLK + 8);

    $display("Ran %0d loads, %0d restarts and %0d allocations, %0d of them granted,",
             shadow.loads, shadow.restarts, shadow.allocs, shadow.grants);
    $display("across all four policies with block counts of 0, 1, 4, 16, 31 and random ones.");
    if (shadow.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
